@@ rtl/llo_pkg.sv @@
// ----------------------------------------------------------------------------
// llo_pkg
// Types and codes shared by the layered lock order checker modules.
// ----------------------------------------------------------------------------
package llo_pkg;

	localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_NOTHING_NEW   = 3'd1;
	localparam logic [2:0] ST_EXCL_OVER_SH  = 3'd2;
	localparam logic [2:0] ST_NOT_ABOVE     = 3'd3;
	localparam logic [2:0] ST_AFTER_EXCL    = 3'd4;
	localparam logic [2:0] ST_BELOW_SHARED  = 3'd5;
	localparam logic [2:0] ST_OVERFLOW      = 3'd6;
	localparam logic [2:0] ST_RELEASE_EMPTY = 3'd7;

	localparam logic signed [15:0] LAYER_MAX = 16'sh7fff;
	localparam logic signed [15:0] LAYER_MIN = -16'sh8000;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        lock_id;
		logic signed [15:0] layer;
		logic               want_exclusive;
		logic               last_in_request;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] stack_depth;
		logic       any_held;
		logic       lock_held;
		logic       lock_held_exclusive;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPD,
		S_CHECK,
		S_WRITE,
		S_PUSH,
		S_REL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic upd;
		logic check;
		logic wr_step;
		logic push;
		logic rel_fin;
		logic clr_pend;
		logic resp_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       last_in_request;
		logic       scan_last;
		logic       check_ok;
		logic       wr_done;
		logic       rsp_free;
	} stat_t;

endpackage

@@ rtl/layered_lock_order_checker.sv @@
// Every accepted item but an unused code walks the lock table, one entry a cycle.
// The input is busy through the scan and a drain step, then an update for an acquire element,
// a release step for a release, and a check, table write and push on a final element.
// A result is loaded in the cycle before the input frees again; an output stall delays both.
// One item is in work at a time; a result waits in its output register meanwhile.
// Reset clears the valid bits, the stack count and the pending request at once.
// ----------------------------------------------------------------------------
// layered_lock_order_checker
// Checks layered lock ordering for one thread with a lock table and a stack.
// ----------------------------------------------------------------------------
module layered_lock_order_checker #(
	parameter int HELD_ENTRIES = 32,
	parameter int STACK_DEPTH  = 16,
	parameter int REQUEST_MAX  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  llo_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output llo_pkg::rsp_t rsp
);

	llo_pkg::cmd_t  cmd;
	llo_pkg::stat_t stat;

	llo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	llo_datapath #(
		.HELD_ENTRIES (HELD_ENTRIES),
		.STACK_DEPTH  (STACK_DEPTH),
		.REQUEST_MAX  (REQUEST_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ rtl/llo_ctrl.sv @@
// ----------------------------------------------------------------------------
// llo_ctrl
// Sequencer that walks the lock table and orders the steps of each item.
// ----------------------------------------------------------------------------
module llo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [1:0]      req_func,
	output logic            req_stall,
	input  llo_pkg::stat_t  stat,
	output llo_pkg::cmd_t   cmd
);

	llo_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llo_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			llo_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					// An unused function code is taken and dropped.
					if (req_func != llo_pkg::FUNC_UNUSED) begin
						cmd.scan_clr = 1'b1;
						state_d      = llo_pkg::S_SCAN;
					end
				end
			end
			llo_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = llo_pkg::S_DRAIN;
			end
			llo_pkg::S_DRAIN: begin
				case (stat.func)
					llo_pkg::FUNC_QUERY:   state_d = llo_pkg::S_RESP;
					llo_pkg::FUNC_RELEASE: state_d = llo_pkg::S_REL;
					default:               state_d = llo_pkg::S_UPD;
				endcase
			end
			llo_pkg::S_UPD: begin
				cmd.upd = 1'b1;
				state_d = stat.last_in_request ? llo_pkg::S_CHECK : llo_pkg::S_IDLE;
			end
			llo_pkg::S_CHECK: begin
				cmd.check    = 1'b1;
				cmd.scan_clr = 1'b1;
				if (stat.check_ok) begin
					state_d = llo_pkg::S_WRITE;
				end else begin
					cmd.clr_pend = 1'b1;
					state_d      = llo_pkg::S_RESP;
				end
			end
			llo_pkg::S_WRITE: begin
				cmd.wr_step = 1'b1;
				if (stat.wr_done) state_d = llo_pkg::S_PUSH;
			end
			llo_pkg::S_PUSH: begin
				cmd.push     = 1'b1;
				cmd.clr_pend = 1'b1;
				state_d      = llo_pkg::S_RESP;
			end
			llo_pkg::S_REL: begin
				cmd.rel_fin  = 1'b1;
				cmd.clr_pend = 1'b1;
				state_d      = llo_pkg::S_RESP;
			end
			llo_pkg::S_RESP: begin
				if (stat.rsp_free) begin
					cmd.resp_load = 1'b1;
					state_d       = llo_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = llo_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/llo_datapath.sv @@
// ----------------------------------------------------------------------------
// llo_datapath
// Lock table, operation stack, pending request buffer and result register.
// ----------------------------------------------------------------------------
module llo_datapath #(
	parameter int HELD_ENTRIES = 32,
	parameter int STACK_DEPTH  = 16,
	parameter int REQUEST_MAX  = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  llo_pkg::req_t   req,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output llo_pkg::rsp_t   rsp,
	input  llo_pkg::cmd_t   cmd,
	output llo_pkg::stat_t  stat
);

	localparam int HIDX_W = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;
	localparam int FREE_W = $clog2(HELD_ENTRIES + 1);
	localparam int LVL_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int OCNT_W = $clog2(STACK_DEPTH + 1);
	localparam int PIDX_W = (REQUEST_MAX > 1) ? $clog2(REQUEST_MAX) : 1;
	localparam int PCNT_W = $clog2(REQUEST_MAX + 1);

	llo_pkg::req_t req_q;

	// Lock table: valid bits in flip-flops, the rest in memory.
	logic [HELD_ENTRIES-1:0] valid_q;
	logic [15:0]             id_mem   [HELD_ENTRIES];
	logic                    mode_mem [HELD_ENTRIES];
	logic [LVL_W-1:0]        lvl_mem  [HELD_ENTRIES];

	logic [HIDX_W-1:0] cnt_q;
	logic              go_s1;
	logic [HIDX_W-1:0] idx_s1;
	logic              vld_s1;
	logic [15:0]       id_s1;
	logic              mode_s1;
	logic [LVL_W-1:0]  lvl_s1;
	logic              hit_q;
	logic              hitx_q;
	logic [FREE_W-1:0] free_q;
	logic [PCNT_W-1:0] k_q;

	// Operation stack.
	logic signed [15:0] stk_layer_mem [STACK_DEPTH];
	logic               stk_ex_mem    [STACK_DEPTH];
	logic signed [15:0] top_layer_q;
	logic               top_ex_q;
	logic [OCNT_W-1:0]  op_cnt_q;
	logic [LVL_W-1:0]   top_idx;
	logic [LVL_W-1:0]   push_idx;

	// Pending request buffer.
	logic [15:0]        pend_id_q [REQUEST_MAX];
	logic [PCNT_W-1:0]  pend_cnt_q;
	logic signed [15:0] pmin_q;
	logic signed [15:0] pmax_q;
	logic [2:0]         perr_q;
	logic               in_pend;

	logic [2:0]  st_q;
	logic [2:0]  chk_status;
	logic        scan_last;
	logic        wr_free;
	logic        id_match;

	llo_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	assign top_idx   = LVL_W'(op_cnt_q - OCNT_W'(1));
	assign push_idx  = LVL_W'(op_cnt_q);
	assign scan_last = (cnt_q == HIDX_W'(HELD_ENTRIES - 1));
	assign wr_free   = !valid_q[cnt_q];
	assign id_match  = vld_s1 && (id_s1 == req_q.lock_id);

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	always_comb begin
		in_pend = 1'b0;
		for (int i = 0; i < REQUEST_MAX; i++) begin
			if ((PCNT_W'(i) < pend_cnt_q) && (pend_id_q[i] == req_q.lock_id)) in_pend = 1'b1;
		end
	end

	always_comb begin
		if (perr_q != llo_pkg::ST_OK) begin
			chk_status = perr_q;
		end else if (pend_cnt_q == '0) begin
			chk_status = llo_pkg::ST_NOTHING_NEW;
		end else if ((op_cnt_q != '0) && req_q.want_exclusive && (pmin_q <= top_layer_q)) begin
			chk_status = llo_pkg::ST_NOT_ABOVE;
		end else if ((op_cnt_q != '0) && !req_q.want_exclusive && top_ex_q
				&& (pmin_q <= top_layer_q)) begin
			chk_status = llo_pkg::ST_AFTER_EXCL;
		end else if ((op_cnt_q != '0) && !req_q.want_exclusive && !top_ex_q
				&& (pmin_q < top_layer_q)) begin
			chk_status = llo_pkg::ST_BELOW_SHARED;
		end else if ((32'(op_cnt_q) >= 32'(STACK_DEPTH)) || (32'(free_q) < 32'(pend_cnt_q))) begin
			chk_status = llo_pkg::ST_OVERFLOW;
		end else begin
			chk_status = llo_pkg::ST_OK;
		end
	end

	// Table memories: registered read for the scan, single write port.
	always_ff @(posedge clk) begin
		if (cmd.wr_step && wr_free) begin
			id_mem[cnt_q]   <= pend_id_q[PIDX_W'(k_q)];
			mode_mem[cnt_q] <= req_q.want_exclusive;
			lvl_mem[cnt_q]  <= push_idx;
		end
		id_s1   <= id_mem[cnt_q];
		mode_s1 <= mode_mem[cnt_q];
		lvl_s1  <= lvl_mem[cnt_q];
		idx_s1  <= cnt_q;
		vld_s1  <= valid_q[cnt_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_layer_mem[push_idx] <= pmax_q;
			stk_ex_mem[push_idx]    <= req_q.want_exclusive;
		end
		top_layer_q <= stk_layer_mem[top_idx];
		top_ex_q    <= stk_ex_mem[top_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_step && wr_free) begin
			valid_q[cnt_q] <= 1'b1;
		end else if (go_s1 && (req_q.func == llo_pkg::FUNC_RELEASE) && vld_s1
				&& (lvl_s1 == top_idx)) begin
			// Entries tagged with the top level are freed as the scan passes.
			valid_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			go_s1  <= 1'b0;
			hit_q  <= 1'b0;
			hitx_q <= 1'b0;
			free_q <= '0;
			k_q    <= '0;
		end else begin
			go_s1 <= cmd.scan_step;
			if (cmd.scan_clr) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				hitx_q <= 1'b0;
				k_q    <= '0;
				if (!cmd.check) free_q <= '0;
			end else if (cmd.scan_step || cmd.wr_step) begin
				cnt_q <= cnt_q + HIDX_W'(1);
				if (cmd.wr_step && wr_free) k_q <= k_q + PCNT_W'(1);
			end
			if (go_s1) begin
				if (id_match && !hit_q) begin
					hit_q  <= 1'b1;
					hitx_q <= mode_s1;
				end
				if (!vld_s1) free_q <= free_q + FREE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && !hit_q && !in_pend && (32'(pend_cnt_q) < 32'(REQUEST_MAX))) begin
			pend_id_q[PIDX_W'(pend_cnt_q)] <= req_q.lock_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
			pmin_q     <= llo_pkg::LAYER_MAX;
			pmax_q     <= llo_pkg::LAYER_MIN;
			perr_q     <= llo_pkg::ST_OK;
		end else if (cmd.clr_pend) begin
			pend_cnt_q <= '0;
			pmin_q     <= llo_pkg::LAYER_MAX;
			pmax_q     <= llo_pkg::LAYER_MIN;
			perr_q     <= llo_pkg::ST_OK;
		end else if (cmd.upd) begin
			if (hit_q) begin
				if (req_q.want_exclusive && !hitx_q && (perr_q == llo_pkg::ST_OK)) begin
					perr_q <= llo_pkg::ST_EXCL_OVER_SH;
				end
			end else if (!in_pend) begin
				if (32'(pend_cnt_q) >= 32'(REQUEST_MAX)) begin
					if (perr_q == llo_pkg::ST_OK) perr_q <= llo_pkg::ST_OVERFLOW;
				end else begin
					pend_cnt_q <= pend_cnt_q + PCNT_W'(1);
					if (req_q.layer < pmin_q) pmin_q <= req_q.layer;
					if (req_q.layer > pmax_q) pmax_q <= req_q.layer;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_cnt_q <= '0;
			st_q     <= llo_pkg::ST_OK;
		end else begin
			if (cmd.load) st_q <= llo_pkg::ST_OK;
			if (cmd.check) st_q <= chk_status;
			if (cmd.push) op_cnt_q <= op_cnt_q + OCNT_W'(1);
			if (cmd.rel_fin) begin
				if (op_cnt_q == '0) begin
					st_q <= llo_pkg::ST_RELEASE_EMPTY;
				end else begin
					op_cnt_q <= op_cnt_q - OCNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			rsp_q.status              <= st_q;
			rsp_q.stack_depth         <= 5'(32'(op_cnt_q));
			rsp_q.any_held            <= (op_cnt_q != '0);
			rsp_q.lock_held           <= (req_q.func == llo_pkg::FUNC_QUERY) && hit_q;
			rsp_q.lock_held_exclusive <= (req_q.func == llo_pkg::FUNC_QUERY) && hit_q && hitx_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		stat.func            = req_q.func;
		stat.last_in_request = req_q.last_in_request;
		stat.scan_last       = scan_last;
		stat.check_ok        = (chk_status == llo_pkg::ST_OK);
		stat.wr_done         = scan_last || (wr_free && ((k_q + PCNT_W'(1)) == pend_cnt_q));
		stat.rsp_free        = !rsp_valid_q || !rsp_stall;
	end

endmodule

@@ sim/tb_layered_lock_order_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_layered_lock_order_checker
// Drives acquire runs, releases and queries into the lock order checker and
// compares every response against a behavioural lock table and stack kept
// in the bench, under several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_layered_lock_order_checker;

	localparam int N_HELD  = 32;
	localparam int N_STACK = 16;
	localparam int N_REQ   = 8;
	localparam longint CYCLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	llo_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	llo_pkg::rsp_t rsp;

	// Behavioural copy of the checker state.
	logic [15:0]        tbl_id [N_HELD];
	logic               tbl_vld [N_HELD];
	logic               tbl_ex [N_HELD];
	int                 tbl_lvl [N_HELD];
	logic signed [15:0] stk_layer [N_STACK];
	logic               stk_ex [N_STACK];
	int                 depth;
	logic [15:0]        run_id [N_REQ];
	int                 run_n;
	logic signed [15:0] run_min;
	logic signed [15:0] run_max;
	logic [2:0]         run_err;

	llo_pkg::rsp_t expected_rsps [$];
	int   errors;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_off;
	longint cycles;

	layered_lock_order_checker uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int find_lock(logic [15:0] id);
		for (int i = 0; i < N_HELD; i++)
			if (tbl_vld[i] && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void clear_run();
		run_n = 0;
		run_min = llo_pkg::LAYER_MAX;
		run_max = llo_pkg::LAYER_MIN;
		run_err = llo_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] commit_run(logic ex);
		int free_n;
		int k;
		if (run_err != llo_pkg::ST_OK)
			return run_err;
		if (run_n == 0)
			return llo_pkg::ST_NOTHING_NEW;
		if (depth > 0) begin
			if (ex) begin
				if (run_min <= stk_layer[depth-1])
					return llo_pkg::ST_NOT_ABOVE;
			end else if (stk_ex[depth-1]) begin
				if (run_min <= stk_layer[depth-1])
					return llo_pkg::ST_AFTER_EXCL;
			end else if (run_min < stk_layer[depth-1]) begin
				return llo_pkg::ST_BELOW_SHARED;
			end
		end
		free_n = 0;
		for (int i = 0; i < N_HELD; i++)
			if (!tbl_vld[i])
				free_n++;
		if (depth >= N_STACK || free_n < run_n)
			return llo_pkg::ST_OVERFLOW;
		k = 0;
		for (int i = 0; i < N_HELD && k < run_n; i++) begin
			if (!tbl_vld[i]) begin
				tbl_vld[i] = 1'b1;
				tbl_id[i] = run_id[k];
				tbl_ex[i] = ex;
				tbl_lvl[i] = depth;
				k++;
			end
		end
		stk_layer[depth] = run_max;
		stk_ex[depth] = ex;
		depth++;
		return llo_pkg::ST_OK;
	endfunction

	// Advances the bench state by one item; returns 1 when a response follows.
	function automatic bit predict_lock_item(llo_pkg::req_t r, output llo_pkg::rsp_t o);
		int h;
		o = '0;
		case (r.func)
			llo_pkg::FUNC_ACQUIRE: begin
				h = find_lock(r.lock_id);
				if (h >= 0) begin
					if (r.want_exclusive && !tbl_ex[h] && run_err == llo_pkg::ST_OK)
						run_err = llo_pkg::ST_EXCL_OVER_SH;
				end else begin
					bit dup;
					dup = 0;
					for (int i = 0; i < run_n; i++)
						if (run_id[i] == r.lock_id)
							dup = 1;
					if (!dup) begin
						if (run_n >= N_REQ) begin
							if (run_err == llo_pkg::ST_OK)
								run_err = llo_pkg::ST_OVERFLOW;
						end else begin
							run_id[run_n] = r.lock_id;
							run_n++;
							if (r.layer < run_min)
								run_min = r.layer;
							if (r.layer > run_max)
								run_max = r.layer;
						end
					end
				end
				if (!r.last_in_request)
					return 0;
				o.status = commit_run(r.want_exclusive);
				clear_run();
			end
			llo_pkg::FUNC_RELEASE: begin
				clear_run();
				if (depth == 0) begin
					o.status = llo_pkg::ST_RELEASE_EMPTY;
				end else begin
					depth--;
					for (int i = 0; i < N_HELD; i++)
						if (tbl_vld[i] && tbl_lvl[i] == depth)
							tbl_vld[i] = 1'b0;
				end
			end
			llo_pkg::FUNC_QUERY: begin
				h = find_lock(r.lock_id);
				if (h >= 0) begin
					o.lock_held = 1'b1;
					o.lock_held_exclusive = tbl_ex[h];
				end
			end
			default: return 0;
		endcase
		o.stack_depth = depth[4:0];
		o.any_held = (depth != 0);
		return 1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Valid stays up after a transfer when the next item follows at once.
	task automatic send_item(llo_pkg::req_t r);
		llo_pkg::rsp_t o;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		if (predict_lock_item(r, o))
			expected_rsps.push_back(o);
	endtask

	// Receiver: random stalls plus an optional long hold-off.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		llo_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected response", 1, 0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status != want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.stack_depth != want.stack_depth)
					report_mismatch("stack_depth", rsp.stack_depth, want.stack_depth);
				if (rsp.any_held != want.any_held)
					report_mismatch("any_held", rsp.any_held, want.any_held);
				if (rsp.lock_held != want.lock_held)
					report_mismatch("lock_held", rsp.lock_held, want.lock_held);
				if (rsp.lock_held_exclusive != want.lock_held_exclusive)
					report_mismatch("lock_held_exclusive", rsp.lock_held_exclusive,
						want.lock_held_exclusive);
			end
		end
	end

	function automatic llo_pkg::req_t make_item(logic [1:0] f, logic [15:0] id,
			logic signed [15:0] ly, logic ex, logic last);
		llo_pkg::req_t r;
		r.func = f;
		r.lock_id = id;
		r.layer = ly;
		r.want_exclusive = ex;
		r.last_in_request = last;
		return r;
	endfunction

	// Lock ids are drawn from a small pool mostly so that skips and queries hit.
	function automatic logic [15:0] pick_id();
		if ($urandom_range(9) < 8)
			return 16'($urandom_range(40));
		return 16'($urandom);
	endfunction

	task automatic test_directed();
		send_item(make_item(llo_pkg::FUNC_RELEASE, 16'h0, 16'sh0, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_QUERY, 16'hffff, 16'sh0, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0000, llo_pkg::LAYER_MIN, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0000, llo_pkg::LAYER_MAX, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'hffff, -16'sd5, 1'b0, 1'b1));
		send_item(make_item(llo_pkg::FUNC_QUERY, 16'hffff, 16'sh0, 1'b0, 1'b0));
		// exclusive over a lock held shared
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0000, 16'sd10, 1'b1, 1'b1));
		// everything already held
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'hffff, 16'sd10, 1'b0, 1'b1));
		// shared at the same layer passes, shared below fails
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0005, -16'sd5, 1'b0, 1'b1));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0006, -16'sd6, 1'b0, 1'b1));
		// exclusive not above
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0007, -16'sd5, 1'b1, 1'b1));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0007, llo_pkg::LAYER_MAX, 1'b1, 1'b1));
		send_item(make_item(llo_pkg::FUNC_QUERY, 16'h0007, 16'sh0, 1'b0, 1'b0));
		// shared after exclusive
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0008, llo_pkg::LAYER_MAX, 1'b0, 1'b1));
		// unused code and a release inside a run
		send_item(make_item(llo_pkg::FUNC_UNUSED, 16'h1234, 16'sh0, 1'b1, 1'b1));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'h0009, 16'sd1, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_QUERY, 16'h0009, 16'sh0, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_RELEASE, 16'h0, 16'sh0, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_RELEASE, 16'h0, 16'sh0, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_RELEASE, 16'h0, 16'sh0, 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_RELEASE, 16'h0, 16'sh0, 1'b0, 1'b0));
	endtask

	// Request buffer overflow within one run, with a duplicate id.
	task automatic test_request_overflow();
		for (int i = 0; i < N_REQ + 1; i++)
			send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'(100 + i), 16'(i), 1'b0, 1'b0));
		send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'd100, 16'sd0, 1'b0, 1'b1));
	endtask

	// Fill the lock table until runs overflow it, then unwind the stack.
	task automatic test_table_and_stack_full();
		for (int op = 0; op < N_STACK + 2; op++)
			for (int i = 0; i < 3; i++)
				send_item(make_item(llo_pkg::FUNC_ACQUIRE, 16'(1000 + op * 4 + i),
					16'(op * 10 - 32000), 1'b0, 1'(i == 2)));
		for (int op = 0; op < N_STACK + 1; op++)
			send_item(make_item(llo_pkg::FUNC_RELEASE, 16'h0, 16'sh0, 1'b0, 1'b0));
	endtask

	task automatic test_random(int n);
		int sent;
		int len;
		logic ex;
		logic signed [15:0] base;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					len = $urandom_range(1, N_REQ + 1);
					ex = 1'($urandom_range(1));
					base = (depth > 0) ? stk_layer[depth-1] : -16'sd1000;
					for (int i = 0; i < len; i++) begin
						logic signed [15:0] ly;
						ly = ($urandom_range(9) == 0) ? 16'($urandom)
							: base + 16'($urandom_range(200)) - 16'sd10;
						send_item(make_item(llo_pkg::FUNC_ACQUIRE, pick_id(), ly,
							($urandom_range(15) == 0) ? ~ex : ex, 1'(i == len - 1)));
						sent++;
					end
				end
				5, 6: begin
					send_item(make_item(llo_pkg::FUNC_RELEASE, 16'($urandom),
						16'($urandom), 1'($urandom), 1'($urandom)));
					sent++;
				end
				7, 8: begin
					send_item(make_item(llo_pkg::FUNC_QUERY, pick_id(), 16'($urandom),
						1'($urandom), 1'($urandom)));
					sent++;
				end
				default: begin
					send_item(make_item(2'($urandom_range(3)), 16'($urandom),
						16'($urandom), 1'($urandom), 1'($urandom)));
					sent++;
				end
			endcase
		end
	endtask

	task automatic test_hold_off();
		hold_off <= 400;
		for (int i = 0; i < 12; i++)
			send_item(make_item(llo_pkg::FUNC_QUERY, pick_id(), 16'sh0, 1'b0, 1'b0));
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		errors = 0;
		cycles = 0;
		hold_off = 0;
		send_idle_pct = 31;
		recv_idle_pct = 82;
		for (int i = 0; i < N_HELD; i++)
			tbl_vld[i] = 1'b0;
		depth = 0;
		clear_run();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_request_overflow();
		test_table_and_stack_full();
		test_hold_off();
		test_random(450);
		send_idle_pct = 82;
		recv_idle_pct = 31;
		test_random(450);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(450);
		req_valid <= 1'b0;

		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (2 * N_HELD + 20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
rtl/llo_pkg.sv
rtl/llo_ctrl.sv
rtl/llo_datapath.sv
rtl/layered_lock_order_checker.sv
sim/tb_layered_lock_order_checker.sv
